// ----- sv/heap_sorter_top_macros.svh -----
// Assertion macros shared by the heap sorter checker files.
// Each macro expands to one labeled concurrent assertion on i_clk, disabled in reset.
`ifndef HEAP_SORTER_TOP_MACROS_SVH
`define HEAP_SORTER_TOP_MACROS_SVH

// Same-cycle implication.
`define HS_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HS_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/hs_pkg.sv -----
// Heap sorter package: sizes, controller states, command and status bundles.
// Used by hs_ctrl, hs_dpath and heap_sorter_top; depends on nothing.
package hs_pkg;

    localparam int MAX_ELEMENTS = 32;
    localparam int DATA_W       = 32;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int EXT_W        = CNT_W + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_SORT_START,
        S_SW_RD0,
        S_SW_RD1,
        S_SW_WR,
        S_DN_RD0,
        S_DN_RD1,
        S_DN_CMP,
        S_EM_RD,
        S_EM_WAIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic ovf_set;
        logic up_read;
        logic up_step;
        logic up_place;
        logic sort_init;
        logic sw_rd_root;
        logic sw_rd_last;
        logic sw_swap;
        logic dn_rd_child;
        logic dn_rd_child2;
        logic dn_step;
        logic dn_place;
        logic emit_rd;
        logic emit_load;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic count_full;
        logic last;
        logic pos_zero;
        logic item_gt;
        logic count_gt1;
        logic child_oob;
        logic child_gt;
        logic size_gt2;
        logic out_free;
        logic emit_last;
    } t_stat;

endpackage

// ----- sv/heap_sorter_top.sv -----
// Heap sorter top level: hs_ctrl and hs_dpath over hs_pkg, single-port heap memory.
// Insert: each value is sifted up, one memory read per level.
// Sort: an init step, then for every held value but one a swap, then a sift-down.
// Emit: each result is read, then loaded into the output register once it is free; input is stalled until emit ends.
// Reset (synchronous, active low) empties the store and clears overflow and output valid.
module heap_sorter_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [hs_pkg::DATA_W-1:0] i_element_value,
    input  logic                             i_is_last,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [hs_pkg::DATA_W-1:0] o_sorted_value,
    output logic                             o_run_end,
    output logic                             o_overflowed
);

    hs_pkg::t_cmd  cmd;
    hs_pkg::t_stat stat;

    hs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_is_last (i_is_last),
        .i_stat    (stat),
        .o_stall   (o_stall),
        .o_cmd     (cmd)
    );

    hs_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_element_value (i_element_value),
        .i_is_last       (i_is_last),
        .i_stall         (i_stall),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_sorted_value  (o_sorted_value),
        .o_run_end       (o_run_end),
        .o_overflowed    (o_overflowed)
    );

endmodule

// ----- sv/hs_ctrl.sv -----
// Heap sorter controller: sequences insert, sort and emit phases.
// Depends on hs_pkg; drives hs_dpath through t_cmd and reads t_stat.
module hs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_is_last,
    input  hs_pkg::t_stat i_stat,
    output logic          o_stall,
    output hs_pkg::t_cmd  o_cmd
);

    hs_pkg::t_state r_state;
    hs_pkg::t_state n_state;
    hs_pkg::t_state s_after_insert;
    hs_pkg::t_state s_after_sift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        s_after_insert = i_stat.last ? hs_pkg::S_SORT_START : hs_pkg::S_IDLE;
        s_after_sift   = i_stat.size_gt2 ? hs_pkg::S_SW_RD0 : hs_pkg::S_EM_RD;
        n_state        = r_state;
        case (r_state)
            hs_pkg::S_IDLE: begin
                if (i_valid) begin
                    if (i_stat.count_full) begin
                        n_state = i_is_last ? hs_pkg::S_SORT_START : hs_pkg::S_IDLE;
                    end else begin
                        n_state = hs_pkg::S_UP_RD;
                    end
                end
            end
            hs_pkg::S_UP_RD: begin
                n_state = i_stat.pos_zero ? s_after_insert : hs_pkg::S_UP_CMP;
            end
            hs_pkg::S_UP_CMP: begin
                n_state = i_stat.item_gt ? hs_pkg::S_UP_RD : s_after_insert;
            end
            hs_pkg::S_SORT_START: begin
                n_state = i_stat.count_gt1 ? hs_pkg::S_SW_RD0 : hs_pkg::S_EM_RD;
            end
            hs_pkg::S_SW_RD0: n_state = hs_pkg::S_SW_RD1;
            hs_pkg::S_SW_RD1: n_state = hs_pkg::S_SW_WR;
            hs_pkg::S_SW_WR:  n_state = hs_pkg::S_DN_RD0;
            hs_pkg::S_DN_RD0: begin
                n_state = i_stat.child_oob ? s_after_sift : hs_pkg::S_DN_RD1;
            end
            hs_pkg::S_DN_RD1: n_state = hs_pkg::S_DN_CMP;
            hs_pkg::S_DN_CMP: begin
                n_state = i_stat.child_gt ? hs_pkg::S_DN_RD0 : s_after_sift;
            end
            hs_pkg::S_EM_RD: n_state = hs_pkg::S_EM_WAIT;
            hs_pkg::S_EM_WAIT: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.emit_last ? hs_pkg::S_IDLE : hs_pkg::S_EM_RD;
                end
            end
            default: n_state = hs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            hs_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.accept  = 1'b1;
                    o_cmd.ovf_set = i_stat.count_full;
                end
            end
            hs_pkg::S_UP_RD: begin
                if (i_stat.pos_zero) begin
                    o_cmd.up_place = 1'b1;
                end else begin
                    o_cmd.up_read = 1'b1;
                end
            end
            hs_pkg::S_UP_CMP: begin
                if (i_stat.item_gt) begin
                    o_cmd.up_step = 1'b1;
                end else begin
                    o_cmd.up_place = 1'b1;
                end
            end
            hs_pkg::S_SORT_START: o_cmd.sort_init  = 1'b1;
            hs_pkg::S_SW_RD0:     o_cmd.sw_rd_root = 1'b1;
            hs_pkg::S_SW_RD1:     o_cmd.sw_rd_last = 1'b1;
            hs_pkg::S_SW_WR:      o_cmd.sw_swap    = 1'b1;
            hs_pkg::S_DN_RD0: begin
                if (i_stat.child_oob) begin
                    o_cmd.dn_place = 1'b1;
                end else begin
                    o_cmd.dn_rd_child = 1'b1;
                end
            end
            hs_pkg::S_DN_RD1: o_cmd.dn_rd_child2 = 1'b1;
            hs_pkg::S_DN_CMP: begin
                if (i_stat.child_gt) begin
                    o_cmd.dn_step = 1'b1;
                end else begin
                    o_cmd.dn_place = 1'b1;
                end
            end
            hs_pkg::S_EM_RD: o_cmd.emit_rd = 1'b1;
            hs_pkg::S_EM_WAIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    o_cmd.clear     = i_stat.emit_last;
                end
            end
            default: o_stall = 1'b1;
        endcase
    end

endmodule

// ----- sv/hs_dpath.sv -----
// Heap sorter datapath: heap memory, item and index registers, output register.
// Depends on hs_pkg; steered by hs_ctrl through t_cmd, reports t_stat.
module hs_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  hs_pkg::t_cmd                     i_cmd,
    input  logic signed [hs_pkg::DATA_W-1:0] i_element_value,
    input  logic                             i_is_last,
    input  logic                             i_stall,
    output hs_pkg::t_stat                    o_stat,
    output logic                             o_valid,
    output logic signed [hs_pkg::DATA_W-1:0] o_sorted_value,
    output logic                             o_run_end,
    output logic                             o_overflowed
);

    logic signed [hs_pkg::DATA_W-1:0] r_mem [hs_pkg::MAX_ELEMENTS];
    logic signed [hs_pkg::DATA_W-1:0] r_rdata;
    logic signed [hs_pkg::DATA_W-1:0] r_item;
    logic signed [hs_pkg::DATA_W-1:0] r_tmp;
    logic signed [hs_pkg::DATA_W-1:0] r_cval;
    logic [hs_pkg::IDX_W-1:0]         r_pos;
    logic [hs_pkg::CNT_W-1:0]         r_count;
    logic [hs_pkg::CNT_W-1:0]         r_size;
    logic [hs_pkg::CNT_W-1:0]         r_k;
    logic                             r_ovf;
    logic                             r_last;
    logic                             r_o_valid;
    logic signed [hs_pkg::DATA_W-1:0] r_o_value;
    logic                             r_o_end;
    logic                             r_o_ovf;

    logic [hs_pkg::IDX_W-1:0]         parent_idx;
    logic [hs_pkg::IDX_W-1:0]         last_idx;
    logic [hs_pkg::EXT_W-1:0]         child_x;
    logic [hs_pkg::EXT_W-1:0]         child2_x;
    logic [hs_pkg::EXT_W-1:0]         hs_x;
    logic                             child2_oob;
    logic                             pick2;
    logic signed [hs_pkg::DATA_W-1:0] chosen_val;
    logic [hs_pkg::IDX_W-1:0]         chosen_idx;
    logic                             mem_re;
    logic [hs_pkg::IDX_W-1:0]         mem_raddr;
    logic                             mem_we;
    logic [hs_pkg::IDX_W-1:0]         mem_waddr;
    logic signed [hs_pkg::DATA_W-1:0] mem_wdata;

    assign parent_idx = (r_pos - hs_pkg::IDX_W'(1)) >> 1;
    assign last_idx   = hs_pkg::IDX_W'(r_size - hs_pkg::CNT_W'(1));
    assign child_x    = hs_pkg::EXT_W'({r_pos, 1'b1});
    assign child2_x   = child_x + hs_pkg::EXT_W'(1);
    assign hs_x       = hs_pkg::EXT_W'(r_size) - hs_pkg::EXT_W'(1);
    assign child2_oob = child2_x >= hs_x;
    assign pick2      = !child2_oob && (r_rdata > r_cval);
    assign chosen_val = pick2 ? r_rdata : r_cval;
    assign chosen_idx = pick2 ? child2_x[hs_pkg::IDX_W-1:0] : child_x[hs_pkg::IDX_W-1:0];

    always_comb begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        if (i_cmd.up_read) begin
            mem_raddr = parent_idx;
        end else if (i_cmd.sw_rd_last) begin
            mem_raddr = last_idx;
        end else if (i_cmd.dn_rd_child) begin
            mem_raddr = child_x[hs_pkg::IDX_W-1:0];
        end else if (i_cmd.dn_rd_child2) begin
            mem_raddr = child2_x[hs_pkg::IDX_W-1:0];
            mem_re    = !child2_oob;
        end else if (i_cmd.emit_rd) begin
            mem_raddr = r_k[hs_pkg::IDX_W-1:0];
        end else if (!i_cmd.sw_rd_root) begin
            mem_re = 1'b0;
        end
    end

    always_comb begin
        mem_we    = 1'b1;
        mem_waddr = r_pos;
        mem_wdata = r_item;
        if (i_cmd.up_step) begin
            mem_wdata = r_rdata;
        end else if (i_cmd.sw_swap) begin
            mem_waddr = last_idx;
            mem_wdata = r_tmp;
        end else if (i_cmd.dn_step) begin
            mem_wdata = chosen_val;
        end else if (!i_cmd.up_place && !i_cmd.dn_place) begin
            mem_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_element_value;
            r_pos  <= r_count[hs_pkg::IDX_W-1:0];
        end
        if (i_cmd.up_step) begin
            r_pos <= parent_idx;
        end
        if (i_cmd.sort_init) begin
            r_size <= r_count;
            r_k    <= '0;
        end
        if (i_cmd.sw_rd_last) begin
            r_tmp <= r_rdata;
        end
        if (i_cmd.sw_swap) begin
            r_item <= r_rdata;
            r_pos  <= '0;
        end
        if (i_cmd.dn_rd_child2) begin
            r_cval <= r_rdata;
        end
        if (i_cmd.dn_step) begin
            r_pos <= chosen_idx;
        end
        if (i_cmd.dn_place) begin
            r_size <= r_size - hs_pkg::CNT_W'(1);
        end
        if (i_cmd.emit_load) begin
            r_k       <= r_k + hs_pkg::CNT_W'(1);
            r_o_value <= r_rdata;
            r_o_end   <= o_stat.emit_last;
            r_o_ovf   <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_last    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_last <= i_is_last;
            end
            if (i_cmd.ovf_set) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.up_place) begin
                r_count <= r_count + hs_pkg::CNT_W'(1);
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
            if (i_cmd.emit_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.count_full = r_count == hs_pkg::CNT_W'(hs_pkg::MAX_ELEMENTS);
        o_stat.last       = r_last;
        o_stat.pos_zero   = r_pos == '0;
        o_stat.item_gt    = r_item > r_rdata;
        o_stat.count_gt1  = r_count > hs_pkg::CNT_W'(1);
        o_stat.child_oob  = child_x >= hs_x;
        o_stat.child_gt   = chosen_val > r_item;
        o_stat.size_gt2   = r_size > hs_pkg::CNT_W'(2);
        o_stat.out_free   = !r_o_valid || !i_stall;
        o_stat.emit_last  = (r_k + hs_pkg::CNT_W'(1)) == r_count;
    end

    assign o_valid        = r_o_valid;
    assign o_sorted_value = r_o_value;
    assign o_run_end      = r_o_end;
    assign o_overflowed   = r_o_ovf;

endmodule

// ----- sv/hs_chk.sv -----
// Heap sorter port checker: run ordering, overflow flag and output hold rules.
// Depends on hs_pkg and heap_sorter_top_macros.svh; bound to heap_sorter_top.
`include "heap_sorter_top_macros.svh"

module hs_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_stall,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic signed [hs_pkg::DATA_W-1:0] o_sorted_value,
    input logic                             o_run_end,
    input logic                             o_overflowed
);

    logic                             out_acc;
    logic                             r_in_run;
    logic signed [hs_pkg::DATA_W-1:0] r_prev_value;
    logic                             r_prev_ovf;

    assign out_acc = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run <= 1'b0;
        end else if (out_acc) begin
            r_in_run <= !o_run_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_acc) begin
            r_prev_value <= o_sorted_value;
            r_prev_ovf   <= o_overflowed;
        end
    end

    `HS_ASSERT_NOW(a_ascending, out_acc && r_in_run, o_sorted_value >= r_prev_value, "result out of order")
    `HS_ASSERT_NOW(a_ovf_steady, out_acc && r_in_run, o_overflowed == r_prev_ovf, "overflow flag changed in run")
    `HS_ASSERT_NOW(a_no_req_in_run, r_in_run && !o_valid && i_valid, o_stall, "input open while run in progress")
    `HS_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_sorted_value) && $stable(o_run_end) && $stable(o_overflowed), "stalled result changed")

endmodule

bind heap_sorter_top hs_chk u_hs_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_sorted_value (o_sorted_value),
    .o_run_end      (o_run_end),
    .o_overflowed   (o_overflowed)
);
